// ----- src/ups_line_status_monitor_core_macros.svh -----
// assertion macros for the ups line status monitor
`ifndef UPS_LINE_STATUS_MONITOR_CORE_MACROS_SVH
`define UPS_LINE_STATUS_MONITOR_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define ULSM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("ulsm assertion failed");
`define ULSM_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("ulsm assertion failed");
`else
`define ULSM_ASSERT(lbl, prop)
`define ULSM_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// ----- src/ulsm_pkg.sv -----
// types, constants and helpers shared by the ups line status monitor
`timescale 1ns / 1ps
`default_nettype none

package ulsm_pkg;

  localparam int LineBits   = 9;
  localparam int PeriodBits = 16;
  localparam int CountBits  = 4;
  localparam int AlertBits  = 7;
  localparam int CfgBits    = 16;
  localparam int CfgIdxBits = 3;

  localparam logic [CountBits-1:0] CountMax = '1;

  // alert flag bit positions
  localparam int AlConnErr  = 0;
  localparam int AlConnOk   = 1;
  localparam int AlNoPower  = 2;
  localparam int AlRestored = 3;
  localparam int AlFailed   = 4;
  localparam int AlBattLow  = 5;
  localparam int AlBattOk   = 6;

  typedef enum logic [2:0] {
    NtNone  = 3'd0,
    NtOk    = 3'd1,
    NtFail  = 3'd2,
    NtScram = 3'd3,
    NtCable = 3'd4
  } notice_e;

  typedef enum logic [CfgIdxBits-1:0] {
    RegPowerMask   = 3'd0,
    RegBatteryMask = 3'd1,
    RegCableMask   = 3'd2,
    RegPolarity    = 3'd3,
    RegDebounce    = 3'd4,
    RegBattPeriod  = 3'd5,
    RegCablePeriod = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [LineBits-1:0]   power_mask;
    logic [LineBits-1:0]   battery_mask;
    logic [LineBits-1:0]   cable_mask;
    logic [2:0]            polarity;
    logic [CountBits-1:0]  debounce;
    logic [PeriodBits-1:0] batt_period;
    logic [PeriodBits-1:0] cable_period;
  } cfg_t;

  typedef struct packed {
    logic                  last_pg;
    logic                  last_bg;
    logic [CountBits-1:0]  change_cnt;
    logic                  startup_done;
    logic [PeriodBits-1:0] cable_cnt;
    logic                  cable_was_bad;
    logic [PeriodBits-1:0] batt_cnt;
  } state_t;

  typedef struct packed {
    notice_e              notice;
    logic                 repeated;
    logic [AlertBits-1:0] alerts;
    logic                 holding;
    logic                 cable_bad;
    logic                 power_good;
    logic                 battery_good;
  } result_t;

  localparam state_t StateReset = '{
    last_pg:       1'b1,
    last_bg:       1'b1,
    change_cnt:    '0,
    startup_done:  1'b0,
    cable_cnt:     '0,
    cable_was_bad: 1'b0,
    batt_cnt:      '0
  };

  localparam cfg_t CfgReset = '{
    power_mask:   '0,
    battery_mask: '0,
    cable_mask:   '0,
    polarity:     '0,
    debounce:     4'd4,
    batt_period:  16'd300,
    cable_period: 16'd60
  };

  // reminder counter step, wraps to zero on reaching the period
  function automatic logic [PeriodBits-1:0] step_period(
    input logic [PeriodBits-1:0] count,
    input logic [PeriodBits-1:0] period
  );
    logic [PeriodBits:0] n;
    n = {1'b0, count} + {{PeriodBits{1'b0}}, 1'b1};
    return (n >= {1'b0, period}) ? '0 : n[PeriodBits-1:0];
  endfunction

  // line level after mask and polarity, unused mask reads good
  function automatic logic line_level(
    input logic [LineBits-1:0] lines,
    input logic [LineBits-1:0] mask,
    input logic                inv
  );
    return (mask == '0) ? 1'b1 : ((|(lines & mask)) ^ inv);
  endfunction

endpackage

`default_nettype wire

// ----- src/ups_line_status_monitor_core.sv -----
// ups line status monitor top level: config registers, sample and result stages
// a word goes from the sample register via evaluation to the result register
// throughput: one word per cycle while the output is not stalled, set by the
// single evaluation stage between the sample register and the result register
// reset: asynchronous active-low, loads reset state and config, drops valid flags
`timescale 1ns / 1ps
`default_nettype none

`include "ups_line_status_monitor_core_macros.svh"

module ups_line_status_monitor_core (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [ulsm_pkg::CfgIdxBits-1:0] cfg_idx_i,
  input  wire logic [ulsm_pkg::CfgBits-1:0]    cfg_data_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [ulsm_pkg::LineBits-1:0]   modem_lines_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [2:0]                           notice_o,
  output logic                                 notice_repeated_o,
  output logic [ulsm_pkg::AlertBits-1:0]       alert_flags_o,
  output logic                                 debounce_holding_o,
  output logic                                 cable_bad_o,
  output logic                                 power_good_o,
  output logic                                 battery_good_o
);

  ulsm_pkg::cfg_t                   cfg_q;
  ulsm_pkg::state_t                 state_q;
  ulsm_pkg::state_t                 state_d;
  ulsm_pkg::result_t                res_d;
  ulsm_pkg::result_t                res_q;
  logic [ulsm_pkg::LineBits-1:0]    lines_q;
  logic                             s1_valid_q;
  logic                             out_valid_q;
  logic                             adv;

  // result stage takes a word when empty or being drained
  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= ulsm_pkg::CfgReset;
    end else if (cfg_we_i) begin
      unique case (ulsm_pkg::cfg_idx_e'(cfg_idx_i))
        ulsm_pkg::RegPowerMask:   cfg_q.power_mask   <= cfg_data_i[ulsm_pkg::LineBits-1:0];
        ulsm_pkg::RegBatteryMask: cfg_q.battery_mask <= cfg_data_i[ulsm_pkg::LineBits-1:0];
        ulsm_pkg::RegCableMask:   cfg_q.cable_mask   <= cfg_data_i[ulsm_pkg::LineBits-1:0];
        ulsm_pkg::RegPolarity:    cfg_q.polarity     <= cfg_data_i[2:0];
        ulsm_pkg::RegDebounce:    cfg_q.debounce     <= cfg_data_i[ulsm_pkg::CountBits-1:0];
        ulsm_pkg::RegBattPeriod:  cfg_q.batt_period  <= cfg_data_i;
        ulsm_pkg::RegCablePeriod: cfg_q.cable_period <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ulsm_eval u_eval (
    .lines_i (lines_q),
    .cfg_i   (cfg_q),
    .state_i (state_q),
    .state_o (state_d),
    .res_o   (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= ulsm_pkg::StateReset;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (adv) begin
        out_valid_q <= s1_valid_q;
        if (s1_valid_q) begin
          state_q <= state_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      lines_q <= modem_lines_i;
    end
    if (adv && s1_valid_q) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign notice_o           = res_q.notice;
  assign notice_repeated_o  = res_q.repeated;
  assign alert_flags_o      = res_q.alerts;
  assign debounce_holding_o = res_q.holding;
  assign cable_bad_o        = res_q.cable_bad;
  assign power_good_o       = res_q.power_good;
  assign battery_good_o     = res_q.battery_good;

  `ULSM_ASSERT(a_cable_bad_quiet,
    out_valid_q && res_q.cable_bad |-> res_q.notice == ulsm_pkg::NtNone && !res_q.holding)
  `ULSM_ASSERT(a_repeat_is_scram,
    out_valid_q && res_q.repeated |-> res_q.notice == ulsm_pkg::NtScram)
  `ULSM_ASSERT(a_holding_no_notice,
    out_valid_q && res_q.holding |-> res_q.notice == ulsm_pkg::NtNone)
  `ULSM_ASSERT(a_count_clears,
    adv && s1_valid_q && !res_d.holding && !res_d.cable_bad |=> state_q.change_cnt == '0)
  `ULSM_ASSERT_ALWAYS(a_stall_only_when_full,
    !in_ready_o |-> s1_valid_q && out_valid_q)

endmodule

`default_nettype wire

// ----- src/ulsm_eval.sv -----
// per-sample status evaluation: next state and result word
`timescale 1ns / 1ps
`default_nettype none

module ulsm_eval (
  input  wire logic [ulsm_pkg::LineBits-1:0] lines_i,
  input  wire ulsm_pkg::cfg_t                cfg_i,
  input  wire ulsm_pkg::state_t              state_i,
  output ulsm_pkg::state_t                   state_o,
  output ulsm_pkg::result_t                  res_o
);

  logic                                pg;
  logic                                bg;
  logic                                cable_used;
  logic                                cable_good;
  logic                                lp;
  logic                                lb;
  logic                                change;
  logic [ulsm_pkg::CountBits-1:0]      cnt_inc;

  assign pg         = ulsm_pkg::line_level(lines_i, cfg_i.power_mask, cfg_i.polarity[0]);
  assign bg         = ulsm_pkg::line_level(lines_i, cfg_i.battery_mask, cfg_i.polarity[1]);
  assign cable_used = |cfg_i.cable_mask;
  assign cable_good = (|(lines_i & cfg_i.cable_mask)) ^ cfg_i.polarity[2];

  always_comb begin
    state_o            = state_i;
    res_o              = '0;
    res_o.notice       = ulsm_pkg::NtNone;
    res_o.power_good   = pg;
    res_o.battery_good = bg;
    lp                 = state_i.last_pg;
    lb                 = state_i.last_bg;
    change             = 1'b0;
    cnt_inc            = (state_i.change_cnt == ulsm_pkg::CountMax) ?
                         ulsm_pkg::CountMax : state_i.change_cnt + 1'b1;

    if (cable_used && !cable_good) begin
      // sample held while the cable reads bad
      res_o.cable_bad = 1'b1;
      if (state_i.cable_cnt == '0) begin
        res_o.alerts[ulsm_pkg::AlConnErr] = 1'b1;
      end
      state_o.cable_cnt     = ulsm_pkg::step_period(state_i.cable_cnt, cfg_i.cable_period);
      state_o.cable_was_bad = 1'b1;
    end else begin
      if (cable_used) begin
        if (state_i.cable_was_bad) begin
          res_o.alerts[ulsm_pkg::AlConnOk] = 1'b1;
        end
        state_o.cable_was_bad = 1'b0;
        state_o.cable_cnt     = '0;
      end else if (!state_i.startup_done) begin
        state_o.startup_done = 1'b1;
        if (!pg) begin
          res_o.alerts[ulsm_pkg::AlNoPower] = 1'b1;
          lp           = pg;
          lb           = bg;
          res_o.notice = ulsm_pkg::NtCable;
        end
      end

      change = (pg != lp) || (bg != lb);

      if (change && (cnt_inc < cfg_i.debounce)) begin
        res_o.holding      = 1'b1;
        state_o.change_cnt = cnt_inc;
        state_o.last_pg    = lp;
        state_o.last_bg    = lb;
      end else begin
        if (change && (pg != lp)) begin
          if (pg) begin
            res_o.alerts[ulsm_pkg::AlRestored] = 1'b1;
            res_o.notice = ulsm_pkg::NtOk;
          end else if (bg) begin
            res_o.alerts[ulsm_pkg::AlFailed] = 1'b1;
            res_o.notice = ulsm_pkg::NtFail;
          end else begin
            res_o.alerts[ulsm_pkg::AlBattLow] = 1'b1;
            res_o.notice = ulsm_pkg::NtScram;
          end
        end
        if (change && (bg != lb)) begin
          if (!bg && !pg) begin
            res_o.alerts[ulsm_pkg::AlBattLow] = 1'b1;
            res_o.repeated = (res_o.notice == ulsm_pkg::NtScram);
            res_o.notice   = ulsm_pkg::NtScram;
          end else if (bg) begin
            res_o.alerts[ulsm_pkg::AlBattOk] = 1'b1;
          end
        end

        // low battery reminder while on line power
        if (!bg && pg) begin
          if (state_i.batt_cnt == '0) begin
            res_o.alerts[ulsm_pkg::AlBattLow] = 1'b1;
          end
          state_o.batt_cnt = ulsm_pkg::step_period(state_i.batt_cnt, cfg_i.batt_period);
        end else begin
          state_o.batt_cnt = '0;
        end

        state_o.change_cnt = '0;
        state_o.last_pg    = pg;
        state_o.last_bg    = bg;
      end
    end
  end

endmodule

`default_nettype wire

// ----- tb/ups_line_status_monitor_core_test.sv -----
// self-checking testbench for the ups line status monitor core
`timescale 1ns / 1ps

module ups_line_status_monitor_core_test;
  import ulsm_pkg::*;

  localparam int StallLimit    = 4000;
  localparam int RandomPhases  = 7;
  localparam int WordsPerPhase = 92;

  // predicts the status word for every accepted sample and checks the block against it
  class line_status_tracker;
    logic [LineBits-1:0]   pwr_mask, bat_mask, cab_mask;
    logic [2:0]            active_low;
    logic [CountBits-1:0]  confirm_len;
    logic [PeriodBits-1:0] batt_every, cable_every;
    logic                  last_pwr, last_bat, first_seen, cable_down;
    logic [CountBits-1:0]  differ_run;
    logic [PeriodBits-1:0] cable_cnt, batt_cnt;
    result_t               expected_q[$];
    int                    errors, words, notices_seen, holds_seen, cable_words;

    function new();
      pwr_mask    = '0;
      bat_mask    = '0;
      cab_mask    = '0;
      active_low  = '0;
      confirm_len = 4'd4;
      batt_every  = 16'd300;
      cable_every = 16'd60;
      last_pwr    = 1'b1;
      last_bat    = 1'b1;
      first_seen  = 1'b0;
      cable_down  = 1'b0;
      differ_run  = '0;
      cable_cnt   = '0;
      batt_cnt    = '0;
      errors      = 0;
      words       = 0;
      notices_seen = 0;
      holds_seen  = 0;
      cable_words = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [CfgBits-1:0] v);
      case (idx)
        RegPowerMask:   pwr_mask = v[LineBits-1:0];
        RegBatteryMask: bat_mask = v[LineBits-1:0];
        RegCableMask:   cab_mask = v[LineBits-1:0];
        RegPolarity:    active_low = v[2:0];
        RegDebounce:    confirm_len = v[CountBits-1:0];
        RegBattPeriod:  batt_every = v[PeriodBits-1:0];
        RegCablePeriod: cable_every = v[PeriodBits-1:0];
        default: ;
      endcase
    endfunction

    function logic sensed(logic [LineBits-1:0] lines, logic [LineBits-1:0] m, logic inv);
      if (m == '0) return 1'b1;
      return (|(lines & m)) ^ inv;
    endfunction

    function logic [PeriodBits-1:0] next_tick(logic [PeriodBits-1:0] c,
                                              logic [PeriodBits-1:0] p);
      logic [PeriodBits:0] n;
      n = {1'b0, c} + 1'b1;
      return (n >= {1'b0, p}) ? '0 : n[PeriodBits-1:0];
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_sample(logic [LineBits-1:0] lines);
      result_t r;
      logic    pg, bg, stop;
      r = '0;
      r.notice = NtNone;
      pg = sensed(lines, pwr_mask, active_low[0]);
      bg = sensed(lines, bat_mask, active_low[1]);
      r.power_good = pg;
      r.battery_good = bg;
      stop = 1'b0;
      if (cab_mask != '0) begin
        if (!sensed(lines, cab_mask, active_low[2])) begin
          r.cable_bad = 1'b1;
          if (cable_cnt == '0) r.alerts[AlConnErr] = 1'b1;
          cable_cnt = next_tick(cable_cnt, cable_every);
          cable_down = 1'b1;
          stop = 1'b1;
        end else begin
          if (cable_down) begin
            r.alerts[AlConnOk] = 1'b1;
            cable_down = 1'b0;
          end
          cable_cnt = '0;
        end
      end else if (!first_seen) begin
        first_seen = 1'b1;
        if (!pg) begin
          r.alerts[AlNoPower] = 1'b1;
          last_pwr = pg;
          last_bat = bg;
          r.notice = NtCable;
        end
      end
      if (!stop && (pg != last_pwr || bg != last_bat)) begin
        if (differ_run != CountMax) differ_run++;
        if (differ_run < confirm_len) begin
          r.holding = 1'b1;
          stop = 1'b1;
        end else begin
          if (pg != last_pwr) begin
            if (pg) begin
              r.alerts[AlRestored] = 1'b1;
              r.notice = NtOk;
            end else if (bg) begin
              r.alerts[AlFailed] = 1'b1;
              r.notice = NtFail;
            end else begin
              r.alerts[AlBattLow] = 1'b1;
              r.notice = NtScram;
            end
          end
          if (bg != last_bat) begin
            if (!bg && !pg) begin
              r.alerts[AlBattLow] = 1'b1;
              if (r.notice == NtScram) r.repeated = 1'b1;
              r.notice = NtScram;
            end else if (bg) begin
              r.alerts[AlBattOk] = 1'b1;
            end
          end
        end
      end
      if (!stop) begin
        if (!bg && pg) begin
          if (batt_cnt == '0) r.alerts[AlBattLow] = 1'b1;
          batt_cnt = next_tick(batt_cnt, batt_every);
        end else begin
          batt_cnt = '0;
        end
        differ_run = '0;
        last_pwr = pg;
        last_bat = bg;
      end
      expected_q.push_back(r);
    endfunction

    task report(string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    task compare_field(string name, int got, int want);
      if (got != want)
        report($sformatf("word %0d %s: got %0d, expected %0d", words, name, got, want));
    endtask

    task check_word(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        report("status word with no sample waiting");
        return;
      end
      want = expected_q.pop_front();
      compare_field("notice", got.notice, want.notice);
      compare_field("notice_repeated", got.repeated, want.repeated);
      compare_field("alert_flags", got.alerts, want.alerts);
      compare_field("debounce_holding", got.holding, want.holding);
      compare_field("cable_bad", got.cable_bad, want.cable_bad);
      compare_field("power_good", got.power_good, want.power_good);
      compare_field("battery_good", got.battery_good, want.battery_good);
      if (want.notice != NtNone) notices_seen++;
      if (want.holding) holds_seen++;
      if (want.cable_bad) cable_words++;
      words++;
    endtask
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CfgIdxBits-1:0] cfg_idx_i = '0;
  logic [CfgBits-1:0]    cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic [LineBits-1:0]   modem_lines_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [2:0]            notice_o;
  logic                  notice_repeated_o;
  logic [AlertBits-1:0]  alert_flags_o;
  logic                  debounce_holding_o;
  logic                  cable_bad_o;
  logic                  power_good_o;
  logic                  battery_good_o;
  result_t               seen_word;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_cycles = 0;
  int settings_loaded = 0;
  line_status_tracker status_board;

  logic [LineBits-1:0] power_words [10] = '{
    9'h000, 9'h003, 9'h001, 9'h001, 9'h001, 9'h003, 9'h002, 9'h003, 9'h000, 9'h1ff
  };
  logic [LineBits-1:0] cable_words [15] = '{
    9'h000, 9'h100, 9'h100, 9'h100, 9'h010, 9'h010, 9'h010, 9'h030,
    9'h000, 9'h020, 9'h000, 9'h020, 9'h020, 9'h020, 9'h020
  };

  assign seen_word = {notice_o, notice_repeated_o, alert_flags_o, debounce_holding_o,
                      cable_bad_o, power_good_o, battery_good_o};

  ups_line_status_monitor_core u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .modem_lines_i      (modem_lines_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .notice_o           (notice_o),
    .notice_repeated_o  (notice_repeated_o),
    .alert_flags_o      (alert_flags_o),
    .debounce_holding_o (debounce_holding_o),
    .cable_bad_o        (cable_bad_o),
    .power_good_o       (power_good_o),
    .battery_good_o     (battery_good_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) status_board.check_word(seen_word);
      if (in_valid_i && in_ready_o) status_board.note_sample(modem_lines_i);
    end
    out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles == StallLimit) begin
      $display("ups_line_status_monitor_core_test: FAIL");
      $finish;
    end
  end

  task automatic put_reg(cfg_idx_e idx, logic [CfgBits-1:0] v);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= v;
    status_board.set_reg(idx, v);
    @(posedge clk_i);
  endtask

  task automatic load_settings(logic [LineBits-1:0] pm, logic [LineBits-1:0] bm,
                               logic [LineBits-1:0] cm, logic [2:0] pol,
                               logic [CountBits-1:0] deb, logic [PeriodBits-1:0] bp,
                               logic [PeriodBits-1:0] cp);
    put_reg(RegPowerMask, CfgBits'(pm));
    put_reg(RegBatteryMask, CfgBits'(bm));
    put_reg(RegCableMask, CfgBits'(cm));
    put_reg(RegPolarity, CfgBits'(pol));
    put_reg(RegDebounce, CfgBits'(deb));
    put_reg(RegBattPeriod, CfgBits'(bp));
    put_reg(RegCablePeriod, CfgBits'(cp));
    cfg_we_i <= 1'b0;
    settings_loaded++;
  endtask

  task automatic offer_word(logic [LineBits-1:0] lines);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    modem_lines_i <= lines;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (status_board.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic pace_for(int phase);
    case (phase / 3)
      0: begin
        send_idle_pct = 27;
        recv_idle_pct = 82;
      end
      1: begin
        send_idle_pct = 82;
        recv_idle_pct = 27;
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    endcase
  endtask

  function automatic logic [LineBits-1:0] pick_mask();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return LineBits'(1) << $urandom_range(0, LineBits - 1);
      2: return LineBits'($urandom_range(1, 511));
      default: return '1;
    endcase
  endfunction

  function automatic logic [CountBits-1:0] pick_debounce();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return 4'd1;
      2: return 4'd15;
      default: return CountBits'($urandom_range(2, 5));
    endcase
  endfunction

  function automatic logic [PeriodBits-1:0] pick_period();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return 16'd1;
      2: return 16'hffff;
      default: return PeriodBits'($urandom_range(2, 6));
    endcase
  endfunction

  // runs of a steady line pattern so that changes get past the debounce, with odd noisy bits
  task automatic run_random(int count);
    logic [LineBits-1:0] base, lines;
    int run, sent, span;
    sent = 0;
    span = (status_board.confirm_len == '0) ? 1 : int'(status_board.confirm_len);
    while (sent < count) begin
      base = LineBits'($urandom_range(0, 511));
      run = $urandom_range(1, span + 4);
      for (int k = 0; k < run && sent < count; k++) begin
        lines = base;
        if ($urandom_range(0, 15) == 0)
          lines = base ^ (LineBits'(1) << $urandom_range(0, LineBits - 1));
        offer_word(lines);
        sent++;
      end
    end
  endtask

  initial begin
    status_board = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    pace_for(0);
    load_settings(9'h001, 9'h002, 9'h000, 3'b000, 4'd1, 16'd2, 16'd3);
    foreach (power_words[i]) offer_word(power_words[i]);
    settle();

    pace_for(1);
    load_settings(9'h010, 9'h020, 9'h100, 3'b111, 4'd3, 16'd0, 16'd2);
    foreach (cable_words[i]) offer_word(cable_words[i]);
    settle();

    for (int p = 0; p < RandomPhases; p++) begin
      pace_for(p + 2);
      if (p == 0)
        load_settings(9'h1ff, 9'h1ff, 9'h000, 3'b000, 4'd0, 16'd0, 16'd0);
      else if (p == 1)
        load_settings(pick_mask(), pick_mask(), pick_mask(), 3'($urandom_range(0, 7)),
                      4'd15, 16'hffff, 16'hffff);
      else
        load_settings(pick_mask(), pick_mask(), pick_mask(), 3'($urandom_range(0, 7)),
                      pick_debounce(), pick_period(), pick_period());
      run_random(WordsPerPhase);
      settle();
    end

    $display("summary: %0d status words checked under %0d register settings",
             status_board.words, settings_loaded);
    $display("summary: %0d notices, %0d debounce holds, %0d words with the cable down",
             status_board.notices_seen, status_board.holds_seen, status_board.cable_words);
    if (status_board.errors == 0)
      $display("ups_line_status_monitor_core_test: PASS");
    else
      $display("ups_line_status_monitor_core_test: FAIL");
    $finish;
  end

endmodule
